// ===== sv/kfd_pkg.sv =====
// Shared types and constants for the KISS frame deframer.
`default_nettype none

package kfd_pkg;

   localparam logic [7:0] FR_END   = 8'hC0;
   localparam logic [7:0] FR_ESC   = 8'hDB;
   localparam logic [7:0] FR_TEND  = 8'hDC;
   localparam logic [7:0] FR_TESC  = 8'hDD;
   localparam logic [3:0] CMD_DATA  = 4'h0;
   localparam logic [3:0] CMD_RESET = 4'hF;

   localparam int          LEN_W     = 11;
   localparam int          TICK_W    = 16;
   localparam int          COUNT_CAP = 2047;

   localparam logic [LEN_W-1:0]  MAX_PACKET_RESET = 11'd255;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET    = 16'd5000;

   localparam logic CSR_MAX_PACKET_SIZE = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS   = 1'b1;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HUNT,
      PH_FRAME
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_DONE     = 3'd1,
      KIND_RESET    = 3'd2,
      KIND_BADTYPE  = 3'd3,
      KIND_TIMEOUT  = 3'd4,
      KIND_OVERSIZE = 3'd5
   } kind_type;

   // One classified word as it travels through the queue.
   typedef struct packed {
      logic       is_tick;
      logic [7:0] data;
      logic       is_end;
      logic       is_esc;
      logic       is_tend;
      logic       is_tesc;
   } item_type;

endpackage

`default_nettype wire

// ===== sv/kfd_front.sv =====
// Front end: classifies an incoming word before it enters the queue.
`default_nettype none

module kfd_front (
   input  wire logic              req_operation,
   input  wire logic [7:0]        req_rx_byte,
   output kfd_pkg::item_type      item
);

   always_comb begin
      item.is_tick = (req_operation == kfd_pkg::OP_TICK);
      item.data    = req_rx_byte;
      item.is_end  = (req_rx_byte == kfd_pkg::FR_END);
      item.is_esc  = (req_rx_byte == kfd_pkg::FR_ESC);
      item.is_tend = (req_rx_byte == kfd_pkg::FR_TEND);
      item.is_tesc = (req_rx_byte == kfd_pkg::FR_TESC);
   end

endmodule

`default_nettype wire

// ===== sv/kfd_queue.sv =====
// Short queue of classified words between front end and back end.
`default_nettype none

module kfd_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire kfd_pkg::item_type push_item,
   output      logic              pop_valid,
   input  wire logic              pop_ready,
   output      kfd_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   kfd_pkg::item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/kfd_back.sv =====
// Back end: frame state machine, counters and the result register.
`default_nettype none

module kfd_back #(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [10:0]       max_packet_size,
   input  wire logic [15:0]       timeout_ticks,
   input  wire logic              item_valid,
   output      logic              item_ready,
   input  wire kfd_pkg::item_type item,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [2:0]        rsp_kind,
   output      logic [7:0]        rsp_payload_byte,
   output      logic [10:0]       rsp_frame_length,
   output      logic [7:0]        rsp_type_byte,
   output      logic              rsp_last
);

   localparam int LIMIT_CAP = (MAX_FRAME < kfd_pkg::COUNT_CAP) ? MAX_FRAME
                                                                : kfd_pkg::COUNT_CAP;
   localparam logic [10:0] CAP = 11'(LIMIT_CAP);

   kfd_pkg::phase_type phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [10:0] count_ff, count_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] ticks_ff, ticks_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kfd_pkg::kind_type kind_ff, kind_in;
   logic [7:0]        payload_ff, payload_in;
   logic [10:0]       length_ff, length_in;
   logic [7:0]        type_ff, type_in;
   logic              last_ff, last_in;

   logic        pop;
   logic [10:0] limit;
   logic        idle, start, full;
   logic        tick_active, hunt, in_frame, esc_path;
   logic [15:0] ticks_inc;
   logic [10:0] count_inc;
   logic        dec_valid;
   logic [7:0]  dec_byte;
   logic        ev_timeout, ev_oversize, ev_take, ev_close, ev_set_esc;
   logic        ev_open, ev_data, ev_cmd, ends, emit;
   kfd_pkg::kind_type close_kind;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;

   // Classify the popped word against the current frame state.
   always_comb begin
      limit       = (max_packet_size > CAP) ? CAP : max_packet_size;
      idle        = (phase_ff == kfd_pkg::PH_IDLE);
      start       = pop && !item.is_tick && idle;
      full        = (count_ff >= limit);
      ticks_inc   = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
      count_inc   = count_ff + 11'd1;
      tick_active = pop && item.is_tick && !idle;
      hunt        = pop && !item.is_tick && (idle || phase_ff == kfd_pkg::PH_HUNT);
      in_frame    = pop && !item.is_tick && (phase_ff == kfd_pkg::PH_FRAME);
      esc_path    = in_frame && esc_ff;
      dec_valid   = (esc_path && (item.is_tend || item.is_tesc))
                 || (in_frame && !esc_ff && !item.is_end && !item.is_esc);
      dec_byte    = esc_path ? (item.is_tend ? kfd_pkg::FR_END : kfd_pkg::FR_ESC)
                             : item.data;
      ev_timeout  = tick_active && (ticks_inc >= timeout_ticks);
      ev_oversize = (esc_path || dec_valid) && full;
      ev_take     = dec_valid && !full;
      ev_close    = in_frame && !esc_ff && item.is_end && (count_ff != '0);
      ev_set_esc  = in_frame && !esc_ff && item.is_esc;
      ev_open     = hunt && item.is_end;
      ev_data     = ev_take && (count_ff != '0);
      ev_cmd      = ev_take && (count_ff == '0);
      ends        = ev_timeout || ev_oversize || ev_close;
      emit        = ends || ev_data;

      priority if (cmd_ff[3:0] == kfd_pkg::CMD_DATA && count_ff >= 11'd2) begin
         close_kind = kfd_pkg::KIND_DONE;
      end else if (cmd_ff[3:0] == kfd_pkg::CMD_RESET) begin
         close_kind = kfd_pkg::KIND_RESET;
      end else begin
         close_kind = kfd_pkg::KIND_BADTYPE;
      end
   end

   // Next state.
   always_comb begin
      priority if (ends) begin
         phase_in = kfd_pkg::PH_IDLE;
      end else if (ev_open) begin
         phase_in = kfd_pkg::PH_FRAME;
      end else if (start) begin
         phase_in = kfd_pkg::PH_HUNT;
      end else begin
         phase_in = phase_ff;
      end
   end

   // Counters and result register.
   always_comb begin
      esc_in   = esc_ff;
      count_in = count_ff;
      cmd_in   = cmd_ff;
      ticks_in = ticks_ff;
      if (ev_set_esc) begin
         esc_in = 1'b1;
      end else if (esc_path || ends || start) begin
         esc_in = 1'b0;
      end
      if (start) begin
         count_in = '0;
         cmd_in   = '0;
         ticks_in = '0;
      end
      if (ev_take) begin
         count_in = count_inc;
      end
      if (ev_cmd) begin
         cmd_in = dec_byte;
      end
      if (tick_active) begin
         ticks_in = ticks_inc;
      end

      rsp_valid_in = pop ? emit : (rsp_valid_ff && !rsp_ready);
      priority if (ev_timeout) begin
         kind_in = kfd_pkg::KIND_TIMEOUT;
      end else if (ev_oversize) begin
         kind_in = kfd_pkg::KIND_OVERSIZE;
      end else if (ev_close) begin
         kind_in = close_kind;
      end else begin
         kind_in = kfd_pkg::KIND_DATA;
      end
      payload_in = ev_data ? dec_byte : 8'd0;
      length_in  = ev_data ? count_inc : count_ff;
      type_in    = cmd_ff;
      last_in    = ends;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= kfd_pkg::PH_IDLE;
         esc_ff       <= 1'b0;
         count_ff     <= '0;
         cmd_ff       <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         count_ff     <= count_in;
         cmd_ff       <= cmd_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result only when a word is popped and produces one.
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff    <= kind_in;
         payload_ff <= payload_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_type_byte    = type_ff;
   assign rsp_last         = last_ff;

   a_idle_no_escape: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == kfd_pkg::PH_IDLE) |-> !esc_ff)
      else $error("escape pending while idle");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("byte count beyond cap");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (pop && ends) |=> (phase_ff == kfd_pkg::PH_IDLE))
      else $error("frame still open after end status");

   a_data_has_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == kfd_pkg::KIND_DATA) |-> (length_ff >= 11'd2 && !last_ff))
      else $error("data word without command byte");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop)
      else $error("word popped while result stalled");

endmodule

`default_nettype wire

// ===== sv/kiss_frame_deframer.sv =====
// KISS frame deframer top level: configuration registers, front end, queue, back end.
//
// Takes one word per cycle: a serial byte or a millisecond tick. Escapes are undone inside
// a frame, the first decoded byte is the command, later bytes stream out as data words, and
// a closing 0xC0, timeout or oversize gives one end word with last set. A word is accepted
// every cycle while the queue has room. The word is first written into the queue and then
// decoded into the result register when the back end pops it; a stall on the result side
// can hold it in the queue. The queue of QUEUE_DEPTH words fills only while the result side
// stalls, and req_ready drops when it is full. Configuration takes effect at once.
`default_nettype none

module kiss_frame_deframer #(
   parameter int MAX_FRAME   = 1024,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_kind,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [10:0] rsp_frame_length,
   output      logic [7:0]  rsp_type_byte,
   output      logic        rsp_last
);

   logic [10:0] max_packet_ff;
   logic [15:0] timeout_ff;

   kfd_pkg::item_type front_item;
   kfd_pkg::item_type queue_item;
   logic              queue_valid;
   logic              queue_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff <= kfd_pkg::MAX_PACKET_RESET;
         timeout_ff    <= kfd_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kfd_pkg::CSR_MAX_PACKET_SIZE: max_packet_ff <= csr_wdata[10:0];
            kfd_pkg::CSR_TIMEOUT_TICKS:   timeout_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   kfd_front u_front (
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .item          (front_item)
   );

   kfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   kfd_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .max_packet_size  (max_packet_ff),
      .timeout_ticks    (timeout_ff),
      .item_valid       (queue_valid),
      .item_ready       (queue_ready),
      .item             (queue_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_type_byte    (rsp_type_byte),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_kiss_frame_deframer.sv =====
// Self-checking testbench for the KISS frame deframer: directed and random serial words
`timescale 1ns / 1ps

module tb_kiss_frame_deframer;

   localparam int FRAME_CAP     = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 400000;

   typedef struct {
      logic       op;
      logic [7:0] data;
   } serial_word_type;

   typedef struct {
      kfd_pkg::kind_type kind;
      logic [7:0]        payload;
      logic [10:0]       length;
      logic [7:0]        cmd;
      logic              last;
   } deframed_word_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = kfd_pkg::OP_BYTE;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [10:0] rsp_frame_length;
   logic [7:0]  rsp_type_byte;
   logic        rsp_last;

   kiss_frame_deframer #(
      .MAX_FRAME(FRAME_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_frame_length(rsp_frame_length),
      .rsp_type_byte(rsp_type_byte),
      .rsp_last(rsp_last)
   );

   serial_word_type   pending_q[$];
   deframed_word_type expected_q[$];
   serial_word_type   next_word;
   deframed_word_type want_word;

   // decoder state and its copy of the registers
   kfd_pkg::phase_type frame_phase = kfd_pkg::PH_IDLE;
   logic        esc_pending = 1'b0;
   logic [10:0] frame_cnt = '0;
   logic [7:0]  frame_cmd = '0;
   logic [15:0] tick_cnt = '0;
   logic [10:0] cfg_max_packet = kfd_pkg::MAX_PACKET_RESET;
   logic [15:0] cfg_timeout = kfd_pkg::TIMEOUT_RESET;

   int   kind_seen[6];
   int   words_sent = 0;
   int   mismatches = 0;
   int   cycles = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   logic word_taken = 1'b0;
   logic no_idle = 1'b0;
   logic idle_ok;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycles, expected_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // long quiet stretches alternate with stretches where either side may idle
   assign idle_ok = ((cycles / 64) % 3) != 0 && !no_idle;

   function automatic int frame_limit();
      return (int'(cfg_max_packet) > FRAME_CAP) ? FRAME_CAP : int'(cfg_max_packet);
   endfunction

   function automatic void post_result(kfd_pkg::kind_type k, logic [7:0] p);
      deframed_word_type w;
      w.kind    = k;
      w.payload = p;
      w.length  = frame_cnt;
      w.cmd     = frame_cmd;
      w.last    = (k != kfd_pkg::KIND_DATA);
      expected_q.push_back(w);
      kind_seen[int'(k)]++;
      if (k != kfd_pkg::KIND_DATA) begin
         frame_phase = kfd_pkg::PH_IDLE;
         esc_pending = 1'b0;
      end
   endfunction

   function automatic void take_decoded(logic [7:0] b);
      if (int'(frame_cnt) >= frame_limit()) begin
         post_result(kfd_pkg::KIND_OVERSIZE, 8'h00);
         return;
      end
      frame_cnt++;
      if (frame_cnt == 11'd1)
         frame_cmd = b;
      else
         post_result(kfd_pkg::KIND_DATA, b);
   endfunction

   function automatic void deframe_step(logic op, logic [7:0] b);
      if (op == kfd_pkg::OP_TICK) begin
         if (frame_phase == kfd_pkg::PH_IDLE)
            return;
         if (tick_cnt != 16'hFFFF)
            tick_cnt++;
         if (tick_cnt >= cfg_timeout)
            post_result(kfd_pkg::KIND_TIMEOUT, 8'h00);
         return;
      end
      if (frame_phase == kfd_pkg::PH_IDLE) begin
         frame_phase = kfd_pkg::PH_HUNT;
         esc_pending = 1'b0;
         frame_cnt   = '0;
         frame_cmd   = '0;
         tick_cnt    = '0;
      end
      if (frame_phase == kfd_pkg::PH_HUNT) begin
         if (b == kfd_pkg::FR_END)
            frame_phase = kfd_pkg::PH_FRAME;
         return;
      end
      if (esc_pending) begin
         // size check wins over a bad escape
         if (int'(frame_cnt) >= frame_limit()) begin
            post_result(kfd_pkg::KIND_OVERSIZE, 8'h00);
            return;
         end
         esc_pending = 1'b0;
         if (b == kfd_pkg::FR_TEND)
            take_decoded(kfd_pkg::FR_END);
         else if (b == kfd_pkg::FR_TESC)
            take_decoded(kfd_pkg::FR_ESC);
         return;
      end
      if (b == kfd_pkg::FR_END) begin
         if (frame_cnt == 11'd0)
            return;
         if (frame_cmd[3:0] == kfd_pkg::CMD_DATA && frame_cnt >= 11'd2)
            post_result(kfd_pkg::KIND_DONE, 8'h00);
         else if (frame_cmd[3:0] == kfd_pkg::CMD_RESET)
            post_result(kfd_pkg::KIND_RESET, 8'h00);
         else
            post_result(kfd_pkg::KIND_BADTYPE, 8'h00);
         return;
      end
      if (b == kfd_pkg::FR_ESC) begin
         esc_pending = 1'b1;
         return;
      end
      take_decoded(b);
   endfunction

   function automatic void check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // compare results first, then advance the decoder on the accepted word
   always @(posedge clock) begin
      word_taken <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result kind %0d expected nothing actual word", $time, rsp_kind);
            mismatches++;
         end else begin
            want_word = expected_q.pop_front();
            check_field("kind", int'(want_word.kind), int'(rsp_kind));
            check_field("payload_byte", int'(want_word.payload), int'(rsp_payload_byte));
            check_field("frame_length", int'(want_word.length), int'(rsp_frame_length));
            check_field("type_byte", int'(want_word.cmd), int'(rsp_type_byte));
            check_field("last", int'(want_word.last), int'(rsp_last));
         end
      end
      if (!reset && req_valid && req_ready)
         deframe_step(req_operation, req_rx_byte);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         // hold the word until it is taken
      end else begin
         if (idle_ok && send_gap == 0 && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 6);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            next_word = pending_q.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_word.op;
            req_rx_byte   <= next_word.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!idle_ok) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_word(logic op, logic [7:0] b);
      pending_q.push_back(serial_word_type'{op, b});
      words_sent++;
   endtask

   // escape framing bytes the way a sender would
   task automatic push_coded(logic [7:0] b);
      if (b == kfd_pkg::FR_END) begin
         push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
         push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_TEND);
      end else if (b == kfd_pkg::FR_ESC) begin
         push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
         push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_TESC);
      end else begin
         push_word(kfd_pkg::OP_BYTE, b);
      end
   endtask

   task automatic push_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) push_word(1'($urandom_range(0, 1)), 8'($urandom));
   endtask

   task automatic push_random_frame();
      int          n;
      int          pick;
      logic [7:0]  b;
      logic [7:0]  cmd;
      logic [3:0]  hi;
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            b = 8'($urandom);
            push_word(kfd_pkg::OP_BYTE, (b == kfd_pkg::FR_END) ? kfd_pkg::FR_ESC : b);
         end
      end
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      if ($urandom_range(0, 7) == 0)
         push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      hi   = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 19);
      if (pick < 12)
         cmd = {hi, kfd_pkg::CMD_DATA};
      else if (pick < 15)
         cmd = {hi, kfd_pkg::CMD_RESET};
      else
         cmd = 8'($urandom);
      push_coded(cmd);
      n = $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0)
         n = $urandom_range(0, 20);
      repeat (n) begin
         if ($urandom_range(0, 29) == 0) begin
            // drop a bad escape, sometimes on a frame end byte
            b = 8'($urandom);
            if (b == kfd_pkg::FR_TEND || b == kfd_pkg::FR_TESC)
               b = kfd_pkg::FR_END;
            push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
            push_word(kfd_pkg::OP_BYTE, b);
         end
         if ($urandom_range(0, 14) == 0)
            push_word(kfd_pkg::OP_TICK, 8'($urandom));
         if ($urandom_range(0, 3) == 0)
            b = ($urandom_range(0, 1) != 0) ? kfd_pkg::FR_END : kfd_pkg::FR_ESC;
         else
            b = 8'($urandom);
         push_coded(b);
      end
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 25);
         repeat (n) push_word(kfd_pkg::OP_TICK, 8'($urandom));
      end
      if ($urandom_range(0, 9) != 0)
         push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      if (idx == kfd_pkg::CSR_MAX_PACKET_SIZE)
         cfg_max_packet = v[10:0];
      else
         cfg_timeout = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_setting(logic [10:0] max_size, logic [15:0] ticks, int n);
      int target;
      drain();
      csr_write(kfd_pkg::CSR_MAX_PACKET_SIZE, {5'b0, max_size});
      csr_write(kfd_pkg::CSR_TIMEOUT_TICKS, ticks);
      target = words_sent + n;
      while (words_sent < target) begin
         if ($urandom_range(0, 5) == 0)
            push_noise();
         else
            push_random_frame();
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = kfd_pkg::CSR_MAX_PACKET_SIZE;
      csr_wdata     = '0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle tick, hunting junk, empty frame, escapes, bad escape, done
      push_word(kfd_pkg::OP_TICK, 8'hFF);
      push_word(kfd_pkg::OP_BYTE, 8'h11);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, 8'h00);
      push_word(kfd_pkg::OP_BYTE, 8'hFF);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_TEND);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_TESC);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_ESC);
      push_word(kfd_pkg::OP_BYTE, 8'h41);
      push_word(kfd_pkg::OP_BYTE, 8'h00);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      // reset request, command with no data, unknown command
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, 8'h0F);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, 8'h00);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);
      push_word(kfd_pkg::OP_BYTE, 8'hA5);
      push_word(kfd_pkg::OP_BYTE, 8'h7E);
      push_word(kfd_pkg::OP_BYTE, kfd_pkg::FR_END);

      run_setting(11'd2, 16'd3, 80);
      run_setting(11'd1024, 16'd65535, 60);
      run_setting(11'd2047, 16'd1, 80);
      run_setting(11'd3, 16'd20, 80);
      run_setting(11'd16, 16'd5000, 100);
      drain();
      no_idle = 1'b1;
      run_setting(11'd255, 16'd50, 100);
      drain();

      $display("Sent %0d serial words; got %0d data words, %0d done, %0d reset, %0d bad type",
               words_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("Aborts: %0d timeout, %0d oversize, across six register settings",
               kind_seen[4], kind_seen[5]);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
